// ----- rtl/core/fpr_pkg.sv -----
// Package for the firmware page receiver: item and result structs, sizes,
// message tags and the CRC-32C polynomial.
// Depends on nothing.
package fpr_pkg;

  localparam int unsigned ChunkBytes = 64;
  localparam int unsigned PageBytes = 1024;
  localparam int unsigned MaxMessageBytes = 128;
  localparam int unsigned Chunks = PageBytes / ChunkBytes;
  localparam int unsigned HeaderDepth = 12;
  localparam int unsigned ChunkAw = $clog2(ChunkBytes);
  localparam int unsigned PageAw = $clog2(PageBytes);
  localparam int unsigned MarkAw = $clog2(Chunks);

  localparam logic [31:0] CrcPoly = 32'h82f6_3b78;

  localparam logic [6:0] PosDecide = 7'd7;
  localparam logic [6:0] PosFlash = 7'd11;
  localparam logic [6:0] PosChunkEnd = 7'(ChunkBytes + 7);

  localparam logic [23:0] TagBlo = 24'h42_4c_4f;
  localparam logic [31:0] TagKill = 32'h4b_49_4c_4c;
  localparam logic [31:0] TagBoot = 32'h42_4f_4f_54;
  localparam logic [31:0] TagDoit = 32'h44_4f_49_54;
  localparam logic [31:0] TagFlas = 32'h46_4c_41_53;

  localparam logic [1:0] CmdByte = 2'd0;
  localparam logic [1:0] CmdOutcome = 2'd1;
  localparam logic [1:0] CmdRead = 2'd2;

  localparam logic [1:0] ActNone = 2'd0;
  localparam logic [1:0] ActErase = 2'd1;
  localparam logic [1:0] ActReboot = 2'd2;
  localparam logic [1:0] ActProgram = 2'd3;

  localparam logic [1:0] MarkAbsent = 2'd0;
  localparam logic [1:0] MarkGood = 2'd1;
  localparam logic [1:0] MarkBad = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] byte_index;
    logic [7:0] data_byte;
    logic       flash_failed;
    logic [9:0] read_address;
  } item_t;

  typedef struct packed {
    logic        restart_packet;
    logic [1:0]  action;
    logic [31:0] program_address;
    logic [1:0]  chunk_status;
    logic [7:0]  progress;
    logic        page_error;
    logic [7:0]  read_data;
  } result_t;

endpackage

// ----- rtl/core/firmware_page_receiver.sv -----
// Firmware page receiver: decodes bootloader messages byte by byte, checks
// chunks and pages with a bit-serial CRC-32C and reports one result per item.
// Depends on fpr_pkg.
//
// An item is transferred when start is high and busy is low; every item
// gives exactly one result transfer, shown for one cycle with done_o high,
// and the receiver cannot stall it. After reset the block sweeps the page
// buffer to zero, holding busy high while it does so. A plain message byte,
// an outcome or a read spends most of its time in the bit-serial progress
// division (one quotient bit a cycle). A chunk end runs the CRC over the 64
// staged bytes and a good chunk is then copied into the page buffer. A page
// check runs the CRC over the 1024-byte buffer, and a failed check or a
// flash outcome adds a clearing sweep. The CRC unit handles one bit a cycle
// and both buffers have one write port and one registered read port. The
// configuration register may be written at any time the block is idle.
module firmware_page_receiver import fpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  item_t       item_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  output logic        done_o,
  output result_t     result_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_CRC_RD, S_CRC_BIT, S_CHECK, S_COPY, S_CLEAR,
    S_READ, S_READ2, S_DIV_INIT, S_DIV_SAT, S_DIV_STEP
  } state_e;

  state_e state_q;
  item_t item_q;
  result_t res_q;
  logic valid_q;
  logic [31:0] base_q, total_q, done_pages_q, chunks_q;
  logic pending_q;
  logic [7:0] hdr_q [HeaderDepth];
  logic [1:0] marks_q [Chunks];
  logic [31:0] crc_q;
  logic [7:0] sh_q;
  logic [2:0] bit_q;
  logic [10:0] cnt_q;
  logic src_page_q;
  logic clr_idle_q;
  logic [39:0] rem_q;
  logic [43:0] dsh_q;
  logic [7:0] quo_q;

  logic [7:0] page_mem [PageBytes];
  logic [7:0] stage_mem [ChunkBytes];
  logic [7:0] pg_rdata_q, stg_rdata_q;
  logic pg_we;
  logic [PageAw-1:0] pg_waddr, pg_raddr;
  logic [7:0] pg_wdata;
  logic stg_we;
  logic [ChunkAw-1:0] stg_waddr, stg_raddr;

  logic accept;
  logic [31:0] word4, word8;
  logic hdr_blo, hdr_kill, hdr_boot, hdr_doit, hdr_flas, all_good;
  logic [7:0] crc_byte;
  logic crc_fb;
  logic [31:0] crc_next;
  logic [MarkAw-1:0] chunk_n;
  logic last_byte;
  logic div_ge;

  assign accept = start && !busy;
  assign busy = (state_q != S_IDLE);
  assign done_o = valid_q;
  assign result_o = res_q;

  assign word4 = {hdr_q[4], hdr_q[5], hdr_q[6], hdr_q[7]};
  assign word8 = {hdr_q[8], hdr_q[9], hdr_q[10], hdr_q[11]};
  assign hdr_blo = ({hdr_q[0], hdr_q[1], hdr_q[2]} == TagBlo);
  assign hdr_kill = ({hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3]} == TagKill);
  assign hdr_boot = ({hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3]} == TagBoot);
  assign hdr_doit = ({hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3]} == TagDoit);
  assign hdr_flas = ({hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3]} == TagFlas);
  assign chunk_n = hdr_q[3][MarkAw-1:0];

  always_comb begin
    all_good = 1'b1;
    for (int i = 0; i < Chunks; i++) begin
      if (marks_q[i] != MarkGood) all_good = 1'b0;
    end
  end

  // Bit-serial CRC step: the first bit of a byte comes straight from the
  // memory read register, later bits from the shift register.
  assign crc_byte = (bit_q == 3'd0) ? (src_page_q ? pg_rdata_q : stg_rdata_q) : sh_q;
  assign crc_fb = crc_q[0] ^ crc_byte[0];
  assign crc_next = {1'b0, crc_q[31:1]} ^ (crc_fb ? CrcPoly : 32'd0);
  assign last_byte = src_page_q ? (cnt_q == 11'(PageBytes - 1))
                                : (cnt_q == 11'(ChunkBytes - 1));
  assign div_ge = ({4'd0, rem_q} >= dsh_q);

  // Memory port selection.
  always_comb begin
    pg_we = 1'b0;
    pg_waddr = cnt_q[PageAw-1:0];
    pg_wdata = 8'd0;
    pg_raddr = cnt_q[PageAw-1:0];
    stg_raddr = cnt_q[ChunkAw-1:0];
    if (state_q == S_CLEAR) begin
      pg_we = 1'b1;
    end else if (state_q == S_COPY && cnt_q != 11'd0) begin
      pg_we = 1'b1;
      pg_waddr = {chunk_n, 6'(cnt_q[ChunkAw-1:0] - 1'b1)};
      pg_wdata = stg_rdata_q;
    end
    if (state_q == S_READ) pg_raddr = item_q.read_address;
  end

  assign stg_we = accept && (item_i.cmd == CmdByte) && (item_i.byte_index >= 7'd8)
                  && (item_i.byte_index < 7'(ChunkBytes + 8));
  assign stg_waddr = 6'(item_i.byte_index - 7'd8);

  always_ff @(posedge clk_i) begin
    if (pg_we) page_mem[pg_waddr] <= pg_wdata;
    pg_rdata_q <= page_mem[pg_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stg_we) stage_mem[stg_waddr] <= item_i.data_byte;
    stg_rdata_q <= stage_mem[stg_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_idle_q <= 1'b1;
      valid_q <= 1'b0;
      base_q <= '0;
      total_q <= '0;
      done_pages_q <= '0;
      chunks_q <= '0;
      pending_q <= 1'b0;
      crc_q <= '1;
      cnt_q <= '0;
      bit_q <= '0;
      src_page_q <= 1'b0;
      for (int i = 0; i < HeaderDepth; i++) hdr_q[i] <= '0;
      for (int i = 0; i < Chunks; i++) marks_q[i] <= MarkAbsent;
    end else begin
      valid_q <= 1'b0;
      if (cfg_we_i) base_q <= cfg_data_i;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            item_q <= item_i;
            res_q <= '0;
            if (item_i.cmd == CmdByte && item_i.byte_index < 7'(HeaderDepth)) begin
              hdr_q[item_i.byte_index[3:0]] <= item_i.data_byte;
            end
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_q <= S_DIV_INIT;
          clr_idle_q <= 1'b0;
          cnt_q <= '0;
          bit_q <= '0;
          crc_q <= '1;
          unique case (item_q.cmd)
            CmdByte: begin
              if (item_q.byte_index == PosChunkEnd && hdr_blo) begin
                res_q.restart_packet <= 1'b1;
                if (hdr_q[3] < 8'(Chunks)) begin
                  src_page_q <= 1'b0;
                  state_q <= S_CRC_RD;
                end
              end
              if (item_q.byte_index == PosDecide) begin
                if (hdr_kill) begin
                  res_q.action <= ActErase;
                  res_q.restart_packet <= 1'b1;
                end else if (hdr_boot) begin
                  res_q.action <= ActReboot;
                end else if (hdr_doit) begin
                  for (int i = 0; i < Chunks; i++) marks_q[i] <= MarkAbsent;
                  total_q <= word4;
                  done_pages_q <= '0;
                  chunks_q <= '0;
                end
              end
              if (item_q.byte_index == PosFlash && hdr_flas) begin
                res_q.restart_packet <= 1'b1;
                if (all_good) begin
                  src_page_q <= 1'b1;
                  state_q <= S_CRC_RD;
                end else begin
                  res_q.page_error <= 1'b1;
                  for (int i = 0; i < Chunks; i++) marks_q[i] <= MarkAbsent;
                  state_q <= S_CLEAR;
                end
              end
            end
            CmdOutcome: begin
              if (pending_q) begin
                pending_q <= 1'b0;
                if (item_q.flash_failed) begin
                  res_q.page_error <= 1'b1;
                end else begin
                  done_pages_q <= done_pages_q + 32'd1;
                  if (done_pages_q + 32'd1 == total_q) res_q.action <= ActReboot;
                end
                for (int i = 0; i < Chunks; i++) marks_q[i] <= MarkAbsent;
                state_q <= S_CLEAR;
              end
            end
            CmdRead: state_q <= S_READ;
            default: state_q <= S_DIV_INIT;
          endcase
        end
        S_CRC_RD: begin
          state_q <= S_CRC_BIT;
        end
        S_CRC_BIT: begin
          crc_q <= crc_next;
          sh_q <= {1'b0, crc_byte[7:1]};
          bit_q <= bit_q + 3'd1;
          if (bit_q == 3'd7) begin
            cnt_q <= cnt_q + 11'd1;
            state_q <= last_byte ? S_CHECK : S_CRC_RD;
          end
        end
        S_CHECK: begin
          cnt_q <= '0;
          if (!src_page_q) begin
            if (~crc_q == word4) begin
              marks_q[chunk_n] <= MarkGood;
              chunks_q <= chunks_q + 32'd1;
              res_q.chunk_status <= 2'd1;
              state_q <= S_COPY;
            end else begin
              marks_q[chunk_n] <= MarkBad;
              res_q.chunk_status <= 2'd2;
              state_q <= S_DIV_INIT;
            end
          end else if (~crc_q == word8) begin
            res_q.action <= ActProgram;
            res_q.program_address <= base_q + word4;
            pending_q <= 1'b1;
            state_q <= S_DIV_INIT;
          end else begin
            res_q.page_error <= 1'b1;
            for (int i = 0; i < Chunks; i++) marks_q[i] <= MarkAbsent;
            state_q <= S_CLEAR;
          end
        end
        S_COPY: begin
          cnt_q <= cnt_q + 11'd1;
          if (cnt_q == 11'(ChunkBytes)) state_q <= S_DIV_INIT;
        end
        S_CLEAR: begin
          cnt_q <= cnt_q + 11'd1;
          if (cnt_q == 11'(PageBytes - 1)) begin
            state_q <= clr_idle_q ? S_IDLE : S_DIV_INIT;
            clr_idle_q <= 1'b0;
          end
        end
        S_READ: state_q <= S_READ2;
        S_READ2: begin
          res_q.read_data <= pg_rdata_q;
          state_q <= S_DIV_INIT;
        end
        S_DIV_INIT: begin
          if (total_q == 32'd0) begin
            res_q.progress <= 8'd255;
            valid_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            rem_q <= {chunks_q, 8'd0} - {8'd0, chunks_q};
            dsh_q <= {total_q, 12'd0};
            quo_q <= '0;
            bit_q <= '0;
            state_q <= S_DIV_SAT;
          end
        end
        S_DIV_SAT: begin
          if (div_ge) begin
            res_q.progress <= 8'd255;
            valid_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            dsh_q <= {1'b0, dsh_q[43:1]};
            state_q <= S_DIV_STEP;
          end
        end
        S_DIV_STEP: begin
          if (div_ge) rem_q <= rem_q - dsh_q[39:0];
          quo_q <= {quo_q[6:0], div_ge};
          dsh_q <= {1'b0, dsh_q[43:1]};
          bit_q <= bit_q + 3'd1;
          if (bit_q == 3'd7) begin
            res_q.progress <= {quo_q[6:0], div_ge};
            valid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
